@@ hdl/assert_macros.svh @@
// Assertion macros shared by the translator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, muted while reset is high.
`define BCFT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked check that also holds during reset.
`define BCFT_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ hdl/bcft_pkg.sv @@
// Shared types and constants of the CAN frame translator.
`default_nettype none

package bcft_pkg;

   // beat widths
   localparam int REQ_TDATA_W  = 80;
   localparam int RSP_TDATA_W  = 80;
   localparam int REQ_LEN_LSB  = 11;
   localparam int REQ_BYTE_LSB = 15;
   localparam int RSP_BYTE_LSB = 10;

   // incoming identifiers
   localparam logic [10:0] ID_STATUS = 11'h500;
   localparam logic [10:0] ID_ALARMS = 11'h501;
   localparam logic [10:0] ID_LIMITS = 11'h502;
   localparam logic [10:0] ID_INFO   = 11'h503;
   localparam logic [10:0] ID_TEMP   = 11'h504;

   // minimum length per identifier, 0x500 first
   localparam logic [3:0] MIN_LEN [5] = '{4'd8, 4'd8, 4'd8, 4'd8, 4'd7};

   // outgoing identifiers
   localparam logic [9:0] OID_STATE  = 10'h351;
   localparam logic [9:0] OID_SOC    = 10'h355;
   localparam logic [9:0] OID_LIMITS = 10'h356;
   localparam logic [9:0] OID_ALARM  = 10'h35A;

   // order of the emitted frames
   localparam logic [1:0] FRM_STATE  = 2'd0;
   localparam logic [1:0] FRM_SOC    = 2'd1;
   localparam logic [1:0] FRM_LIMITS = 2'd2;
   localparam logic [1:0] FRM_ALARM  = 2'd3;

   localparam logic [7:0] PERCENT_MAX = 8'd100;
   localparam logic [7:0] FILL_BYTE   = 8'hFF;

   // queue between front and back
   localparam int QDEPTH = 2;
   localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // pack state captured at a status frame
   typedef struct packed {
      logic [15:0]      voltage;
      logic [15:0]      current;
      logic [7:0]       soc;
      logic [7:0]       soh;
      logic [15:0]      alarm;
      logic [15:0]      protect;
      logic [3:0][15:0] limits;
      logic [7:0]       temp;
   } snap_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_stat_type;

endpackage

`default_nettype wire

@@ hdl/bms_can_frame_translator.sv @@
// Top level of the battery CAN to gateway frame translator.
//
//  channel | dir | handshake             | beat contents
//  --------+-----+-----------------------+-----------------------------------------------
//  req     | in  | req_tvalid/req_tready | received CAN frame: id, length, 8 payload bytes
//  rsp     | out | rsp_tvalid/rsp_tready | gateway frame: id, 8 payload bytes, tlast
//  csr     | in  | csr_valid/csr_ready   | translate enable bit
//
//  One req beat is taken per cycle while the snapshot queue (two entries) has room.
//  A status frame with translation on yields four rsp beats, one per cycle from the
//  formatter while rsp_tready stays high; the first passes through the snapshot queue
//  and then the output register.
//  Other frames update stored state in the cycle they are taken and give no beat.
//  Reset (synchronous) zeroes stored state, the enable bit and the queue.
//  rsp back-pressure fills the queue, then drops req_tready; csr is always ready.
`default_nettype none

module bms_can_frame_translator (
   input  wire                               clock,
   input  wire                               reset,
   // [10:0] frame_id, [14:11] frame_len, [22:15] data_byte_0 ... [78:71] data_byte_7
   input  wire  [bcft_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  wire                               req_tvalid,
   output logic                              req_tready,
   // [9:0] out_id, [17:10] out_byte_0 ... [73:66] out_byte_7
   output logic [bcft_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic                              rsp_tlast,   // last_frame
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire                               csr_data     // translate_enable
);
   import bcft_pkg::*;

   logic       push, pop;
   snap_type   push_data, head;
   q_stat_type q_stat;

   // classify frames, hold pack state, snapshot on status
   bcft_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .push       (push),
      .push_data  (push_data),
      .q_stat     (q_stat)
   );

   // decouples intake from output back-pressure
   bcft_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .q_stat    (q_stat)
   );

   // four gateway frames per snapshot into the output register
   bcft_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .q_stat     (q_stat),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

@@ hdl/bcft_front.sv @@
// Front end: takes CAN beats, checks id and length, keeps pack state.
`default_nettype none

module bcft_front (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_tvalid,
   output logic                              req_tready,
   input  wire  [bcft_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire                               csr_data,
   output logic                              push,
   output bcft_pkg::snap_type                push_data,
   input  bcft_pkg::q_stat_type              q_stat
);
   import bcft_pkg::*;

   logic        enable_ff;
   snap_type    state_ff, state_in;
   logic [10:0] frame_id;
   logic [3:0]  frame_len;
   logic [7:0]  byte_w [8];
   logic [2:0]  id_off;
   logic        id_ok, len_ok, take, is_status;

   assign csr_ready  = 1'b1;
   assign req_tready = !q_stat.full;

   assign frame_id  = req_tdata[10:0];
   assign frame_len = req_tdata[REQ_LEN_LSB +: 4];

   always_comb begin
      for (int k = 0; k < 8; k++) begin
         byte_w[k] = req_tdata[REQ_BYTE_LSB + 8*k +: 8];
      end
   end

   assign id_ok  = (frame_id >= ID_STATUS) && (frame_id <= ID_TEMP);
   assign id_off = 3'(frame_id - ID_STATUS);
   assign len_ok = id_ok && (frame_len >= MIN_LEN[id_off]);
   assign take   = req_tvalid && req_tready && len_ok;
   assign is_status = (frame_id == ID_STATUS);

   always_comb begin
      state_in = state_ff;
      if (take) begin
         case (frame_id)
            ID_STATUS: begin
               state_in.voltage = {byte_w[1], byte_w[0]};
               state_in.current = {byte_w[3], byte_w[2]};
               state_in.soc     = byte_w[4];
               state_in.soh     = byte_w[5];
            end
            ID_ALARMS: begin
               state_in.alarm   = {byte_w[1], byte_w[0]};
               state_in.protect = {byte_w[3], byte_w[2]};
            end
            ID_LIMITS: begin
               for (int k = 0; k < 4; k++) begin
                  state_in.limits[k] = {byte_w[2*k+1], byte_w[2*k]};
               end
            end
            ID_TEMP: begin
               state_in.temp = byte_w[4];
            end
            default: begin
               state_in = state_ff;
            end
         endcase
      end
   end

   // snapshot includes this frame's own values
   assign push      = take && is_status && enable_ff;
   assign push_data = state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         state_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            enable_ff <= csr_data;
         end
      end
   end

endmodule

`default_nettype wire

@@ hdl/bcft_queue.sv @@
// Short snapshot queue between the front end and the frame formatter.
`default_nettype none

module bcft_queue (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   push,
   input  bcft_pkg::snap_type    push_data,
   input  wire                   pop,
   output bcft_pkg::snap_type    head,
   output bcft_pkg::q_stat_type  q_stat
);
   import bcft_pkg::*;
   `include "assert_macros.svh"

   snap_type          mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign q_stat.empty = (count_ff == '0);
   assign q_stat.full  = (count_ff == QCNT_W'(QDEPTH));
   assign head         = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `BCFT_ASSERT(a_q_no_overflow, push |-> (!q_stat.full || pop), "queue push while full")
   `BCFT_ASSERT(a_q_no_underflow, pop |-> !q_stat.empty, "queue pop while empty")

endmodule

`default_nettype wire

@@ hdl/bcft_back.sv @@
// Back end: turns one snapshot into the four gateway frames.
`default_nettype none

module bcft_back (
   input  wire                               clock,
   input  wire                               reset,
   input  bcft_pkg::snap_type                head,
   input  bcft_pkg::q_stat_type              q_stat,
   output logic                              pop,
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   output logic [bcft_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic                              rsp_tlast
);
   import bcft_pkg::*;
   `include "assert_macros.svh"

   logic [1:0]  frame_idx_ff, frame_idx_in;
   logic        valid_ff, valid_in;
   logic        last_ff;
   logic [9:0]  id_ff;
   logic [7:0]  bytes_ff [8];
   logic [9:0]  id_w;
   logic [7:0]  bytes_w [8];
   logic        load;

   logic signed [19:0] cur_ext, cur10;
   logic        [15:0] cur_sat;
   logic signed [15:0] tmp_ext, tmp10;
   logic        [15:0] soc10, soh10;
   logic        [7:0]  soc_cap, soh_cap, al, wa;
   logic        [15:0] p, a;
   logic               cell_p;

   assign load = !q_stat.empty && (!valid_ff || rsp_tready);
   assign pop  = load && (frame_idx_ff == FRM_ALARM);

   // current * 10, saturated to 16 bits
   assign cur_ext = 20'(signed'(head.current));
   assign cur10   = (cur_ext <<< 3) + (cur_ext <<< 1);
   always_comb begin
      if (cur10[19:15] == 5'b00000 || cur10[19:15] == 5'b11111) begin
         cur_sat = cur10[15:0];
      end else if (cur10[19]) begin
         cur_sat = 16'h8000;
      end else begin
         cur_sat = 16'h7FFF;
      end
   end

   assign tmp_ext = 16'(signed'(head.temp));
   assign tmp10   = (tmp_ext <<< 3) + (tmp_ext <<< 1);

   assign soc10   = ({8'd0, head.soc} << 3) + ({8'd0, head.soc} << 1);
   assign soh10   = ({8'd0, head.soh} << 3) + ({8'd0, head.soh} << 1);
   assign soc_cap = (head.soc > PERCENT_MAX) ? PERCENT_MAX : head.soc;
   assign soh_cap = (head.soh > PERCENT_MAX) ? PERCENT_MAX : head.soh;

   // protection bit wins over the matching warning
   assign p      = head.protect;
   assign a      = head.alarm;
   assign cell_p = p[6] | (|p[11:8]);
   always_comb begin
      al[0] = p[0] | p[14];
      al[1] = p[1] | p[12];
      al[5:2] = p[5:2];
      al[6] = cell_p;
      al[7] = p[13];
      wa[0] = !p[0] & a[0];
      wa[1] = !p[1] & a[1];
      wa[5:2] = ~p[5:2] & a[5:2];
      wa[6] = !cell_p & a[6];
      wa[7] = !p[13] & a[7];
   end

   always_comb begin
      for (int k = 0; k < 8; k++) begin
         bytes_w[k] = 8'd0;
      end
      case (frame_idx_ff)
         FRM_STATE: begin
            id_w = OID_STATE;
            {bytes_w[1], bytes_w[0]} = head.voltage;
            {bytes_w[3], bytes_w[2]} = cur_sat;
            {bytes_w[5], bytes_w[4]} = tmp10;
            bytes_w[6] = soc_cap;
            bytes_w[7] = soh_cap;
         end
         FRM_SOC: begin
            id_w = OID_SOC;
            {bytes_w[1], bytes_w[0]} = soc10;
            {bytes_w[3], bytes_w[2]} = soh10;
            for (int k = 4; k < 8; k++) begin
               bytes_w[k] = FILL_BYTE;
            end
         end
         FRM_LIMITS: begin
            id_w = OID_LIMITS;
            for (int k = 0; k < 4; k++) begin
               {bytes_w[2*k+1], bytes_w[2*k]} = head.limits[k];
            end
         end
         default: begin
            id_w = OID_ALARM;
            bytes_w[0] = al;
            bytes_w[2] = wa;
         end
      endcase
   end

   always_comb begin
      valid_in     = valid_ff;
      frame_idx_in = frame_idx_ff;
      if (load) begin
         valid_in     = 1'b1;
         frame_idx_in = frame_idx_ff + 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         frame_idx_ff <= FRM_STATE;
      end else begin
         valid_ff     <= valid_in;
         frame_idx_ff <= frame_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         id_ff   <= id_w;
         last_ff <= (frame_idx_ff == FRM_ALARM);
         for (int k = 0; k < 8; k++) begin
            bytes_ff[k] <= bytes_w[k];
         end
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = last_ff;
   always_comb begin
      rsp_tdata = '0;
      rsp_tdata[9:0] = id_ff;
      for (int k = 0; k < 8; k++) begin
         rsp_tdata[RSP_BYTE_LSB + 8*k +: 8] = bytes_ff[k];
      end
   end

   `BCFT_ASSERT(a_mid_entry_has_head, (frame_idx_ff != FRM_STATE) |-> !q_stat.empty, "formatter mid-entry with empty queue")
   `BCFT_ASSERT(a_last_is_alarm, (rsp_tvalid && rsp_tlast) |-> (rsp_tdata[9:0] == OID_ALARM), "tlast on a non-alarm frame")
   `BCFT_ASSERT(a_pop_restarts, pop |=> (frame_idx_ff == FRM_STATE), "frame index not back at start after pop")

endmodule

`default_nettype wire

@@ sim/bms_can_frame_translator_test.sv @@
// Self-checking testbench of the battery CAN to gateway frame translator.
`timescale 1ns / 100ps

// received CAN frame as packed into req_tdata, frame_id in the lowest bits
typedef struct packed {
   logic [7:0][7:0] data;
   logic [3:0]      len;
   logic [10:0]     id;
} can_rx_frame_type;

// gateway frame as seen on the rsp side, out_id in the lowest bits
typedef struct packed {
   logic            last;
   logic [7:0][7:0] data;
   logic [9:0]      oid;
} gw_frame_type;

// Mirror of the stored pack state; predicts the gateway frames of each status frame.
class pack_state_mirror;
   bit               translating;
   logic [15:0]      voltage, current, alarm, protect;
   logic [7:0]       soc, soh, temp;
   logic [3:0][15:0] limits;
   gw_frame_type     frames_due[$];
   int               errors, beats_checked, status_translated;

   function new();
      translating = 1'b0;
      voltage = '0; current = '0; alarm = '0; protect = '0;
      soc = '0; soh = '0; temp = '0; limits = '0;
      errors = 0; beats_checked = 0; status_translated = 0;
   endfunction

   function void set_enable(bit on);
      translating = on;
   endfunction

   function int pending();
      return frames_due.size();
   endfunction

   // note one accepted req beat
   function void take_frame(can_rx_frame_type f);
      gw_frame_type g;
      int           amps10, temp10, k;
      logic [7:0]   al, wa;
      if (f.id < bcft_pkg::ID_STATUS || f.id > bcft_pkg::ID_TEMP) return;
      if (f.len < bcft_pkg::MIN_LEN[int'(f.id - bcft_pkg::ID_STATUS)]) return;
      case (f.id)
         bcft_pkg::ID_STATUS: begin
            voltage = f.data[1:0];
            current = f.data[3:2];
            soc     = f.data[4];
            soh     = f.data[5];
         end
         bcft_pkg::ID_ALARMS: begin
            alarm   = f.data[1:0];
            protect = f.data[3:2];
         end
         bcft_pkg::ID_LIMITS: limits = f.data;
         bcft_pkg::ID_TEMP:   temp = f.data[4];
         default: ;
      endcase
      if (f.id != bcft_pkg::ID_STATUS || !translating) return;
      status_translated++;

      // state: current and temperature in tenths, current saturated
      amps10 = int'($signed(current)) * 10;
      if (amps10 > 32767) amps10 = 32767;
      if (amps10 < -32768) amps10 = -32768;
      temp10 = int'($signed(temp)) * 10;
      g.oid       = bcft_pkg::OID_STATE;
      g.last      = 1'b0;
      g.data[1:0] = voltage;
      g.data[3:2] = amps10[15:0];
      g.data[5:4] = temp10[15:0];
      g.data[6]   = (soc > bcft_pkg::PERCENT_MAX) ? bcft_pkg::PERCENT_MAX : soc;
      g.data[7]   = (soh > bcft_pkg::PERCENT_MAX) ? bcft_pkg::PERCENT_MAX : soh;
      frames_due.push_back(g);

      // SOC / SOH in tenths, not capped
      g.oid       = bcft_pkg::OID_SOC;
      g.data[1:0] = 16'(soc * 10);
      g.data[3:2] = 16'(soh * 10);
      g.data[7:4] = {4{bcft_pkg::FILL_BYTE}};
      frames_due.push_back(g);

      g.oid  = bcft_pkg::OID_LIMITS;
      g.data = limits;
      frames_due.push_back(g);

      // protection bit wins over the matching alarm bit
      al = '0;
      wa = '0;
      for (k = 0; k < 6; k++) begin
         if (protect[k]) al[k] = 1'b1;
         else if (alarm[k]) wa[k] = 1'b1;
      end
      if (protect[14]) al[0] = 1'b1;
      if (protect[12]) al[1] = 1'b1;
      if (protect[6] || (|protect[11:8])) al[6] = 1'b1;
      else if (alarm[6]) wa[6] = 1'b1;
      if (protect[13]) al[7] = 1'b1;
      else if (alarm[7]) wa[7] = 1'b1;
      g.oid       = bcft_pkg::OID_ALARM;
      g.last      = 1'b1;
      g.data      = '0;
      g.data[0]   = al;
      g.data[2]   = wa;
      frames_due.push_back(g);
   endfunction

   // compare one accepted rsp beat with the oldest prediction
   function void match_beat(gw_frame_type got);
      gw_frame_type want;
      int           k;
      if (frames_due.size() == 0) begin
         $error("unexpected gateway beat, out_id %h", got.oid);
         errors++;
         return;
      end
      want = frames_due.pop_front();
      beats_checked++;
      if (got.oid !== want.oid) begin
         $error("out_id: expected %h, got %h", want.oid, got.oid);
         errors++;
      end
      for (k = 0; k < 8; k++) begin
         if (got.data[k] !== want.data[k]) begin
            $error("out_byte_%0d: expected %h, got %h (out_id %h)",
                   k, want.data[k], got.data[k], want.oid);
            errors++;
         end
      end
      if (got.last !== want.last) begin
         $error("last_frame: expected %b, got %b", want.last, got.last);
         errors++;
      end
   endfunction
endclass

module bms_can_frame_translator_test;
   import bcft_pkg::*;

   localparam int CYCLE_LIMIT     = 300000;
   localparam int SETTLE_CYCLES   = 16;    // queue of two plus four-beat formatter
   localparam int RSP_HOLD_CYCLES = 120;   // long output stall to back the block up

   logic                   clock;
   logic                   reset;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic                   csr_valid;
   logic                   csr_ready;
   logic                   csr_data;

   pack_state_mirror mirror;
   gw_frame_type     rsp_beat;
   bit               rsp_beat_seen;
   bit               req_calm, rsp_calm;   // no idling while set
   bit               hold_request;         // asks the receiver for one long stall
   int               cycle_count;
   int               frames_offered;
   int               enable_writes;

   bms_can_frame_translator uut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d gateway frames still due",
               cycle_count, mirror.pending());
      $display("[bms_can_frame_translator] ERROR");
      $finish;
   end

   // Output side is sampled at the falling edge: a beat seen here with valid and
   // ready high is taken at the next rising edge.
   always @(negedge clock) begin
      rsp_beat_seen = !reset && rsp_tvalid && rsp_tready;
      if (rsp_beat_seen) begin
         rsp_beat = {rsp_tlast, rsp_tdata[RSP_BYTE_LSB +: 64], rsp_tdata[9:0]};
         mirror.match_beat(rsp_beat);
      end
   end

   // Receiver: random stall after each beat, plus one long hold on request.
   // Exactly one drive of rsp_tready per rising edge.
   initial begin
      int stall_left, hold_left;
      stall_left = 0;
      hold_left  = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_left    = RSP_HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (rsp_beat_seen) stall_left = rsp_calm ? 0 : $urandom_range(0, 5);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   function automatic can_rx_frame_type mk_frame(logic [10:0] id, logic [3:0] len,
                                                 logic [63:0] data);
      can_rx_frame_type f;
      f.id   = id;
      f.len  = len;
      f.data = data;
      return f;
   endfunction

   // payload of a status frame; bytes 6 and 7 are unused and random
   function automatic logic [63:0] status_bytes(logic [15:0] volts, logic [15:0] amps,
                                                logic [7:0] soc, logic [7:0] soh);
      logic [15:0] spare;
      spare = 16'($urandom());
      return {spare, soh, soc, amps, volts};
   endfunction

   // mostly well-formed frames of the five known IDs, some short ones and noise
   function automatic can_rx_frame_type random_frame();
      int          pick;
      logic [10:0] id;
      logic [3:0]  len, need;
      logic [63:0] data;
      pick = $urandom_range(0, 99);
      data = {$urandom(), $urandom()};
      if (pick < 82) begin
         id   = (pick < 35) ? ID_STATUS : ID_STATUS + 11'($urandom_range(1, 4));
         need = MIN_LEN[int'(id - ID_STATUS)];
         len  = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(need, 15)) : need;
         // push current toward the saturation edges now and then
         if (id == ID_STATUS && $urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 3))
               0: data[31:16] = 16'h7FFF;
               1: data[31:16] = 16'h8000;
               2: data[31:16] = 16'h0CCD;
               default: data[31:16] = 16'hF333;
            endcase
         end
      end else if (pick < 91) begin
         id   = ID_STATUS + 11'($urandom_range(0, 4));
         need = MIN_LEN[int'(id - ID_STATUS)];
         len  = 4'($urandom_range(0, need - 1));
      end else begin
         id   = 11'($urandom_range(0, 2047));
         len  = 4'($urandom_range(0, 15));
      end
      return mk_frame(id, len, data);
   endfunction

   // Called at a rising edge, returns at the rising edge where the beat was taken.
   task automatic send_frame(input can_rx_frame_type f);
      int gap;
      gap = req_calm ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {{(REQ_TDATA_W - $bits(f)){1'b0}}, f};
      req_tvalid <= 1'b1;
      do @(negedge clock); while (!req_tready);
      mirror.take_frame(f);
      frames_offered++;
      @(posedge clock);
   endtask

   task automatic send_random(input int count);
      repeat (count) send_frame(random_frame());
   endtask

   // input side quiet, every predicted frame out, formatter given time to finish
   task automatic wait_gateway_idle();
      req_tvalid <= 1'b0;
      while (mirror.pending() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_enable(input bit on);
      csr_data  <= on;
      csr_valid <= 1'b1;
      do @(negedge clock); while (!csr_ready);
      mirror.set_enable(on);
      enable_writes++;
      @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      mirror         = new;
      reset          = 1'b1;
      req_tdata      = '0;
      req_tvalid     = 1'b0;
      rsp_tready     = 1'b0;
      csr_valid      = 1'b0;
      csr_data       = 1'b0;
      req_calm       = 1'b0;
      rsp_calm       = 1'b0;
      hold_request   = 1'b0;
      rsp_beat_seen  = 1'b0;
      frames_offered = 0;
      enable_writes  = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // translation is off out of reset: state moves, nothing comes out
      send_frame(mk_frame(ID_STATUS, 4'd8, status_bytes(16'hFFFF, 16'h1234, 8'd77, 8'd88)));
      send_frame(mk_frame(ID_ALARMS, 4'd8, 64'h0));
      wait_gateway_idle();
      write_enable(1'b1);

      // directed: zero state, extremes, saturation, short frames, foreign IDs
      send_frame(mk_frame(ID_STATUS, 4'd8, status_bytes(16'h0000, 16'h0000, 8'd0, 8'd0)));
      send_frame(mk_frame(ID_ALARMS, 4'd8, {32'h0, 16'h0000, 16'hFFFF}));   // warnings only
      send_frame(mk_frame(ID_LIMITS, 4'd8, {16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF}));
      send_frame(mk_frame(ID_TEMP, 4'd7, {24'hFFFFFF, 8'h80, 32'hFFFFFFFF})); // -128 degC
      send_frame(mk_frame(ID_STATUS, 4'd8, status_bytes(16'hFFFF, 16'h7FFF, 8'd255, 8'd101)));
      send_frame(mk_frame(ID_ALARMS, 4'd8, {32'h0, 16'h7000, 16'hFFFF}));   // high protect bits
      send_frame(mk_frame(ID_STATUS, 4'd8, status_bytes(16'h8000, 16'h8000, 8'd100, 8'd100)));
      send_frame(mk_frame(ID_ALARMS, 4'd8, {32'h0, 16'h0800, 16'h00FF}));   // cell group bit
      send_frame(mk_frame(ID_TEMP, 4'd15, {24'h0, 8'h7F, 32'h0}));
      send_frame(mk_frame(ID_STATUS, 4'd15, status_bytes(16'h1234, 16'h0CCD, 8'd101, 8'd99)));
      send_frame(mk_frame(ID_STATUS, 4'd7, status_bytes(16'hAAAA, 16'h5555, 8'd1, 8'd2)));
      send_frame(mk_frame(ID_TEMP, 4'd6, {24'h0, 8'hC0, 32'h0}));           // short, dropped
      send_frame(mk_frame(ID_ALARMS, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF));
      send_frame(mk_frame(ID_INFO, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF));
      send_frame(mk_frame(ID_INFO, 4'd7, 64'h0));
      send_frame(mk_frame(11'h4FF, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF));
      send_frame(mk_frame(11'h505, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF));
      send_frame(mk_frame(11'h7FF, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF));
      send_frame(mk_frame(11'h000, 4'd8, 64'h0));
      send_frame(mk_frame(ID_STATUS, 4'd8, status_bytes(16'h0001, 16'hF333, 8'd50, 8'd0)));
      send_frame(mk_frame(ID_ALARMS, 4'd8, {32'h0, 16'hFFFF, 16'hFFFF}));
      send_frame(mk_frame(ID_LIMITS, 4'd9, 64'h0123_4567_89AB_CDEF));
      send_frame(mk_frame(ID_STATUS, 4'd8, status_bytes(16'h0F0F, 16'hFFFF, 8'd100, 8'd255)));
      wait_gateway_idle();

      // translation off again: the stored state must still track the traffic
      write_enable(1'b0);
      send_random(30);
      wait_gateway_idle();
      write_enable(1'b1);
      send_random(100);

      // long output stall while the sender keeps pushing status frames
      wait_gateway_idle();
      hold_request = 1'b1;
      req_calm     = 1'b1;
      repeat (12)
         send_frame(mk_frame(ID_STATUS, 4'd8,
                             status_bytes(16'($urandom()), 16'($urandom()),
                                          8'($urandom()), 8'($urandom()))));
      req_calm = 1'b0;
      wait_gateway_idle();   // sender holds until every frame is out

      // back-to-back stretch on both sides
      req_calm = 1'b1;
      rsp_calm = 1'b1;
      send_random(50);
      req_calm = 1'b0;
      rsp_calm = 1'b0;
      send_random(90);
      wait_gateway_idle();
      write_enable(1'b0);
      send_random(10);
      wait_gateway_idle();
      write_enable(1'b1);
      send_random(20);
      wait_gateway_idle();

      $display("covered %0d CAN frames, %0d translated status frames, %0d gateway beats",
               frames_offered, mirror.status_translated, mirror.beats_checked);
      $display("with %0d enable writes, one long output stall and back-to-back stretches",
               enable_writes);
      if (mirror.errors == 0 && mirror.pending() == 0) begin
         $display("[bms_can_frame_translator] OK");
      end else begin
         $display("[bms_can_frame_translator] ERROR");
      end
      $finish;
   end

endmodule

@@ bms_can_frame_translator.f @@
+incdir+hdl
hdl/bcft_pkg.sv
hdl/bcft_front.sv
hdl/bcft_queue.sv
hdl/bcft_back.sv
hdl/bms_can_frame_translator.sv
sim/bms_can_frame_translator_test.sv
